@@ hdl/buffer_pool_three_queue_manager_unit_macros.svh @@
// Assertion macros shared by the buffer pool checker.
`ifndef BUFFER_POOL_THREE_QUEUE_MANAGER_UNIT_MACROS_SVH
`define BUFFER_POOL_THREE_QUEUE_MANAGER_UNIT_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define BPQ_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bpq assertion failed");

// Clocked assertion that also checks across reset.
`define BPQ_ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bpq reset assertion failed");

`endif

@@ hdl/bpq_pkg.sv @@
// Types and constants of the buffer pool three-queue manager.
`default_nettype none
package bpq_pkg;

    localparam int NUM_BUFFERS = 16;
    localparam int IDX_W       = $clog2(NUM_BUFFERS);
    localparam int CNT_W       = $clog2(NUM_BUFFERS + 1);

    localparam int REQ_W       = 3;
    localparam int BUF_IDX_W   = 4;
    localparam int OUT_CNT_W   = 5;
    localparam int FAIL_W      = 32;
    localparam int NUM_LISTS   = 3;

    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 56;

    typedef enum logic [REQ_W-1:0] {
        REQ_TAKE_FREE = 3'd0,
        REQ_TAKE_IN   = 3'd1,
        REQ_TAKE_OUT  = 3'd2,
        REQ_PUT_FREE  = 3'd3,
        REQ_PUT_IN    = 3'd4,
        REQ_PUT_OUT   = 3'd5
    } bpq_req_t;

    typedef enum logic [1:0] {
        LIST_FREE = 2'd0,
        LIST_IN   = 2'd1,
        LIST_OUT  = 2'd2
    } bpq_list_t;

    // Declared high field first so the packed image matches tdata, ok in bit 0.
    typedef struct packed {
        logic [FAIL_W-1:0]    free_fail_count;
        logic [OUT_CNT_W-1:0] out_count;
        logic [OUT_CNT_W-1:0] in_count;
        logic [OUT_CNT_W-1:0] free_count;
        logic [BUF_IDX_W-1:0] taken_index;
        logic                 ok;
    } bpq_result_t;

    localparam int RES_W = $bits(bpq_result_t);

endpackage
`default_nettype wire

@@ hdl/bpq_list_engine.sv @@
// List state (heads, tails, counts, links, fail counter) and its registered per-request update.
`default_nettype none
module bpq_list_engine
    import bpq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rstn,
    input  wire logic                 fire,
    input  wire logic [REQ_W-1:0]     req,
    input  wire logic [BUF_IDX_W-1:0] idx,
    output bpq_result_t               res
);

    logic [IDX_W-1:0]  head_reg  [NUM_LISTS];
    logic [IDX_W-1:0]  head_next [NUM_LISTS];
    logic [IDX_W-1:0]  tail_reg  [NUM_LISTS];
    logic [IDX_W-1:0]  tail_next [NUM_LISTS];
    logic [CNT_W-1:0]  count_reg [NUM_LISTS];
    logic [CNT_W-1:0]  count_next[NUM_LISTS];
    logic [FAIL_W-1:0] fail_reg;
    logic [FAIL_W-1:0] fail_next;
    logic [IDX_W-1:0]  link_reg  [NUM_BUFFERS];

    bpq_list_t                   lst;
    logic                        is_take;
    logic                        is_put;
    logic [IDX_W-1:0]            sel_head;
    logic [CNT_W-1:0]            sel_count;
    logic [IDX_W-1:0]            link_rd;
    logic [IDX_W+BUF_IDX_W-1:0]  idx_wide;
    logic                        idx_fits;
    logic [IDX_W-1:0]            idx_n;
    logic                        link_we;
    logic [IDX_W-1:0]            link_waddr;
    logic                        ok;
    logic [IDX_W-1:0]            taken;
    logic [IDX_W+BUF_IDX_W-1:0]  taken_wide;

    always_comb begin
        is_take = 1'b0;
        is_put  = 1'b0;
        lst     = LIST_FREE;
        case (req)
            REQ_TAKE_FREE: begin is_take = 1'b1; lst = LIST_FREE; end
            REQ_TAKE_IN:   begin is_take = 1'b1; lst = LIST_IN;   end
            REQ_TAKE_OUT:  begin is_take = 1'b1; lst = LIST_OUT;  end
            REQ_PUT_FREE:  begin is_put  = 1'b1; lst = LIST_FREE; end
            REQ_PUT_IN:    begin is_put  = 1'b1; lst = LIST_IN;   end
            REQ_PUT_OUT:   begin is_put  = 1'b1; lst = LIST_OUT;  end
            default: begin
                is_take = 1'b0;
                is_put  = 1'b0;
            end
        endcase
    end

    assign sel_head  = head_reg[lst];
    assign sel_count = count_reg[lst];
    assign link_rd   = link_reg[sel_head];
    assign idx_wide  = {{IDX_W{1'b0}}, idx};
    assign idx_fits  = idx_wide < (IDX_W + BUF_IDX_W)'(NUM_BUFFERS);
    assign idx_n     = idx_wide[IDX_W-1:0];
    assign link_waddr = tail_reg[lst];

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        fail_next  = fail_reg;
        link_we    = 1'b0;
        ok         = 1'b0;
        taken      = '0;
        if (is_take) begin
            if (sel_count != '0) begin
                ok              = 1'b1;
                taken           = sel_head;
                head_next[lst]  = link_rd;
                count_next[lst] = sel_count - CNT_W'(1);
            end else if (lst == LIST_FREE) begin
                fail_next = fail_reg + FAIL_W'(1);
            end
        end else if (is_put) begin
            if (idx_fits && (sel_count != CNT_W'(NUM_BUFFERS))) begin
                ok = 1'b1;
                // empty list: new entry becomes head; else chain it behind the tail
                if (sel_count == '0) begin
                    head_next[lst] = idx_n;
                end else begin
                    link_we = 1'b1;
                end
                tail_next[lst]  = idx_n;
                count_next[lst] = sel_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            // free list holds the whole pool, the other two start empty
            for (int i = 0; i < NUM_LISTS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= (i == int'(LIST_FREE)) ? IDX_W'(NUM_BUFFERS - 1) : '0;
                count_reg[i] <= (i == int'(LIST_FREE)) ? CNT_W'(NUM_BUFFERS) : '0;
            end
            fail_reg <= '0;
        end else if (fire) begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fail_reg  <= fail_next;
        end
    end

    // Link table: one write port at the selected tail, reset to ascending chain.
    for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_link
        localparam logic [IDX_W-1:0] LinkRst = IDX_W'((g + 1) % NUM_BUFFERS);
        always_ff @(posedge clk) begin
            if (!rstn) begin
                link_reg[g] <= LinkRst;
            end else if (fire && link_we && (link_waddr == IDX_W'(g))) begin
                link_reg[g] <= idx_n;
            end
        end
    end

    assign taken_wide = {{BUF_IDX_W{1'b0}}, taken};

    always_comb begin
        res.ok              = ok;
        res.taken_index     = taken_wide[BUF_IDX_W-1:0];
        res.free_count      = OUT_CNT_W'(count_next[LIST_FREE]);
        res.in_count        = OUT_CNT_W'(count_next[LIST_IN]);
        res.out_count       = OUT_CNT_W'(count_next[LIST_OUT]);
        res.free_fail_count = fail_next;
    end

endmodule
`default_nettype wire

@@ hdl/buffer_pool_three_queue_manager_unit.sv @@
// Buffer pool three-queue manager: stream wrapper with input and result registers.
// A pool of NUM_BUFFERS buffer indices lives on three FIFO lists (free, input,
// output); after reset all buffers are on the free list in ascending order. Each
// request beat takes the head of one list, appends an index to one list, or (spare
// codes) leaves the lists alone, and yields exactly one result beat with status,
// the taken index, all three counts and the free-list failure count. One request
// is taken per clock unless backpressure stalls the input; a request beat sits in
// the input register, and its result is computed and loaded into the result
// register when that register frees up. The update of heads, tails, counts and the
// one link entry read and written per request sets that rate. Backpressure on the
// result side stalls the input only when both registers are full.
`default_nettype none
module buffer_pool_three_queue_manager_unit
    import bpq_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [2:0] req_type, [6:3] buffer_index, [7] zero
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [0] ok, [4:1] taken_index, [9:5] free_count, [14:10] in_count,
    // [19:15] out_count, [51:20] free_fail_count, [55:52] zero
    output logic [M_DATA_W-1:0]      m_tdata
);

    logic                 in_valid_reg;
    logic [REQ_W-1:0]     in_req_reg;
    logic [BUF_IDX_W-1:0] in_idx_reg;
    logic                 out_valid_reg;
    bpq_result_t          result_reg;
    bpq_result_t          eng_res;
    logic                 advance;
    logic                 fire;

    // The result register frees up when empty or drained this cycle.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    // Request is applied to list state exactly when it moves into the result register.
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg <= s_tdata[REQ_W-1:0];
            in_idx_reg <= s_tdata[REQ_W+BUF_IDX_W-1:REQ_W];
        end
    end

    bpq_list_engine u_engine (
        .clk  (aclk),
        .rstn (aresetn),
        .fire (fire),
        .req  (in_req_reg),
        .idx  (in_idx_reg),
        .res  (eng_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= eng_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, result_reg};

endmodule
`default_nettype wire

@@ hdl/bpq_checker.sv @@
// Port-level checker for the buffer pool manager, bound to the top level.
`default_nettype none
`include "buffer_pool_three_queue_manager_unit_macros.svh"
module bpq_port_checker
    import bpq_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_tready,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    logic counts_ok;

    assign counts_ok = (m_tdata[9:5] <= OUT_CNT_W'(NUM_BUFFERS))
                    && (m_tdata[14:10] <= OUT_CNT_W'(NUM_BUFFERS))
                    && (m_tdata[19:15] <= OUT_CNT_W'(NUM_BUFFERS));

    // A drained result side never blocks the request side.
    `BPQ_ASSERT(a_ready_flow, aclk, aresetn, m_tready |-> s_tready)
    // Stalled result beat holds.
    `BPQ_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // Failed or unused requests report index zero.
    `BPQ_ASSERT(a_fail_idx, aclk, aresetn, m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
    // No list ever holds more than the pool size.
    `BPQ_ASSERT(a_count_max, aclk, aresetn, m_tvalid |-> counts_ok)
    // Reset empties the result register.
    `BPQ_ASSERT_NORST(a_reset_clear, aclk, !aresetn |=> !m_tvalid)

endmodule

bind buffer_pool_three_queue_manager_unit bpq_port_checker u_bpq_checker (.*);
`default_nettype wire

@@ tb/bpq_checker.sv @@
// Buffer pool checker: tracks the three lists from accepted request beats and checks results.
module bpq_checker
    import bpq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  mismatches,
    output int                  pending,
    output int                  checked
);

    logic [IDX_W-1:0]  link_of  [NUM_BUFFERS];
    logic [IDX_W-1:0]  head_of  [NUM_LISTS];
    logic [IDX_W-1:0]  tail_of  [NUM_LISTS];
    logic [CNT_W-1:0]  count_of [NUM_LISTS];
    logic [FAIL_W-1:0] free_fails;

    bpq_result_t expected_q[$];
    int          err_total  = 0;
    int          good_total = 0;

    function automatic bpq_list_t list_of_req(logic [REQ_W-1:0] req);
        case (req)
            REQ_TAKE_IN,  REQ_PUT_IN:  return LIST_IN;
            REQ_TAKE_OUT, REQ_PUT_OUT: return LIST_OUT;
            default:                   return LIST_FREE;
        endcase
    endfunction

    // Applies one request to the list state and returns the result it should produce.
    function automatic bpq_result_t apply_request(logic [REQ_W-1:0] req,
                                                  logic [BUF_IDX_W-1:0] idx);
        bpq_result_t r;
        bpq_list_t   l;
        r = '0;
        l = list_of_req(req);
        case (req)
            REQ_TAKE_FREE, REQ_TAKE_IN, REQ_TAKE_OUT: begin
                if (count_of[l] != 0) begin
                    r.ok          = 1'b1;
                    r.taken_index = head_of[l];
                    head_of[l]    = link_of[head_of[l]];
                    count_of[l]   = count_of[l] - 1'b1;
                end else if (l == LIST_FREE) begin
                    free_fails = free_fails + 1'b1;
                end
            end
            REQ_PUT_FREE, REQ_PUT_IN, REQ_PUT_OUT: begin
                if (int'(idx) < NUM_BUFFERS && int'(count_of[l]) < NUM_BUFFERS) begin
                    if (count_of[l] == 0)
                        head_of[l] = idx;
                    else
                        link_of[tail_of[l]] = idx;
                    tail_of[l]  = idx;
                    count_of[l] = count_of[l] + 1'b1;
                    r.ok        = 1'b1;
                end
            end
            default: ;  // spare codes leave the lists alone
        endcase
        r.free_count      = count_of[LIST_FREE];
        r.in_count        = count_of[LIST_IN];
        r.out_count       = count_of[LIST_OUT];
        r.free_fail_count = free_fails;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_total++;
        end
    endfunction

    always @(posedge aclk) begin
        bpq_result_t want;
        bpq_result_t got;
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUFFERS; i++)
                link_of[i] = IDX_W'((i + 1) % NUM_BUFFERS);
            for (int i = 0; i < NUM_LISTS; i++) begin
                head_of[i]  = '0;
                tail_of[i]  = '0;
                count_of[i] = '0;
            end
            tail_of[LIST_FREE]  = IDX_W'(NUM_BUFFERS - 1);
            count_of[LIST_FREE] = CNT_W'(NUM_BUFFERS);
            free_fails          = '0;
            expected_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = bpq_result_t'(m_tdata[RES_W-1:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, got);
                    err_total++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("ok",              32'(want.ok),          32'(got.ok));
                    check_field("taken_index",     32'(want.taken_index), 32'(got.taken_index));
                    check_field("free_count",      32'(want.free_count),  32'(got.free_count));
                    check_field("in_count",        32'(want.in_count),    32'(got.in_count));
                    check_field("out_count",       32'(want.out_count),   32'(got.out_count));
                    check_field("free_fail_count", want.free_fail_count,  got.free_fail_count);
                    good_total++;
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(apply_request(s_tdata[REQ_W-1:0],
                                                   s_tdata[REQ_W+BUF_IDX_W-1:REQ_W]));
        end
        mismatches <= err_total;
        pending    <= expected_q.size();
        checked    <= good_total;
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the buffer pool three-queue manager: clock, reset, stimulus, verdict.
module tb_top;
    import bpq_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1900;
    localparam int NOISE_ITEMS  = 50;
    localparam int PHASE_ITEMS  = 150;   // items before the traffic rotates to the next list
    localparam int IDLE_PCT     = 21;
    localparam int QUIET_FROM   = 1000;  // cycle window with no idling on either side
    localparam int QUIET_TO     = 1600;
    localparam int HOLD_START   = 500;   // long result stall to back up the pipeline
    localparam int HOLD_LEN     = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int WATCHDOG     = 400000;

    // Request codes the block does not define; they must leave the lists untouched.
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // [2:0] req_type, [6:3] buffer_index, [7] zero
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [0] ok, [4:1] taken_index, [9:5] free_count, [14:10] in_count,
    // [19:15] out_count, [51:20] free_fail_count, [55:52] zero
    logic [M_DATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    int checked;
    int cyc            = 0;
    int sent_total     = 0;
    int directed_total = 0;

    // Stimulus-side view of where each buffer sits, only used to pick legal put indices.
    // It is exact as long as the traffic stays legal, which holds until the noise tail.
    logic [IDX_W-1:0] list_shadow [NUM_LISTS][$];
    logic [IDX_W-1:0] held_q[$];

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk)
        cyc <= cyc + 1;

    buffer_pool_three_queue_manager_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bpq_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    // Random idling, switched off inside the quiet window.
    function automatic bit idle_now();
        if (cyc >= QUIET_FROM && cyc < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    function automatic logic [REQ_W-1:0] req_code(bit is_put, bpq_list_t l);
        case (l)
            LIST_IN:  return is_put ? REQ_PUT_IN  : REQ_TAKE_IN;
            LIST_OUT: return is_put ? REQ_PUT_OUT : REQ_TAKE_OUT;
            default:  return is_put ? REQ_PUT_FREE : REQ_TAKE_FREE;
        endcase
    endfunction

    // Offers one request beat and returns at the edge where it is accepted.
    // tvalid is only lowered when a gap is inserted, so it never toggles within a step.
    task automatic issue_request(input logic [REQ_W-1:0] req, input logic [BUF_IDX_W-1:0] idx);
        while (idle_now()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, idx, req};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent_total++;
    endtask

    // Take from a list; the index field is don't-care and gets the given value.
    task automatic take_from(input bpq_list_t l, input logic [BUF_IDX_W-1:0] junk);
        issue_request(req_code(1'b0, l), junk);
        if (list_shadow[l].size() != 0)
            held_q.push_back(list_shadow[l].pop_front());
    endtask

    // Put a buffer we currently hold onto the tail of a list.
    task automatic put_from_held(input bpq_list_t l, input int pos);
        logic [IDX_W-1:0] idx;
        idx = held_q[pos];
        held_q.delete(pos);
        issue_request(req_code(1'b1, l), idx);
        list_shadow[l].push_back(idx);
    endtask

    // Result side: random stalls, one long hold-off, and a quiet window.
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (cyc == HOLD_START) begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
            end else begin
                m_tready <= !idle_now();
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(2 * CLK_HALF * WATCHDOG);
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        bpq_list_t src;
        bpq_list_t dst;
        bpq_list_t l;
        int        r;

        for (int i = 0; i < NUM_BUFFERS; i++)
            list_shadow[LIST_FREE].push_back(IDX_W'(i));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: full free list, empty takes, spare codes, drain the free list
        // to zero and past it, then the index extremes on the other two lists.
        issue_request(REQ_PUT_FREE, 4'hA);
        take_from(LIST_IN, 4'hF);
        take_from(LIST_OUT, 4'h0);
        issue_request(REQ_SPARE_6, 4'hF);
        issue_request(REQ_SPARE_7, 4'h0);
        repeat (NUM_BUFFERS) take_from(LIST_FREE, BUF_IDX_W'($urandom_range(15)));
        take_from(LIST_FREE, 4'h5);         // empty free take, failure count moves
        put_from_held(LIST_IN, NUM_BUFFERS - 1);   // buffer 15
        put_from_held(LIST_OUT, 0);                // buffer 0
        take_from(LIST_IN, 4'h0);
        take_from(LIST_OUT, 4'hF);
        directed_total = sent_total;

        // Legal traffic with random content. The favored source and destination list
        // rotate every phase so that each list gets drained to empty and filled up.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            src = bpq_list_t'((n / PHASE_ITEMS) % NUM_LISTS);
            dst = bpq_list_t'(((n / PHASE_ITEMS) + 1) % NUM_LISTS);
            r   = $urandom_range(99);
            if (r < 4) begin
                issue_request($urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7,
                              BUF_IDX_W'($urandom_range(15)));
            end else if (r < 52 || held_q.size() == 0) begin
                l = ($urandom_range(99) < 65) ? src : bpq_list_t'($urandom_range(2));
                take_from(l, BUF_IDX_W'($urandom_range(15)));
            end else begin
                l = ($urandom_range(99) < 65) ? dst : bpq_list_t'($urandom_range(2));
                put_from_held(l, $urandom_range(held_q.size() - 1));
            end
        end

        // Noise tail: any code, any index, duplicate puts included. Left for last
        // since duplicates tangle the links and the shadow no longer holds.
        for (int n = 0; n < NOISE_ITEMS; n++)
            issue_request(REQ_W'($urandom_range(7)), BUF_IDX_W'($urandom_range(15)));

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb_top: %0d request beats sent (%0d directed), %0d result beats checked",
                 sent_total, directed_total, checked);
        $display("tb_top: list rotation, empty takes, full-list puts, spare codes, %0d-%s",
                 HOLD_LEN, "cycle result stall, duplicate-put tail");
        if (mismatches == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bpq_pkg.sv
hdl/bpq_list_engine.sv
hdl/buffer_pool_three_queue_manager_unit.sv
hdl/bpq_checker.sv
tb/bpq_checker.sv
tb/tb_top.sv
